// File: rtl/dsns_pkg.sv
// Types, constants and step functions of the depth sensor noise sigma pipeline.
package dsns_pkg;

   localparam int NumStages = 95;

   // stage schedule
   localparam int SqFirst    = 1;
   localparam int SqLast     = 16;
   localparam int ZqLast     = 18;
   localparam int DzStage    = 1;
   localparam int T2MulStage = 2;
   localparam int T2SumStage = 3;
   localparam int CoInit     = 17;
   localparam int CoFirst    = 18;
   localparam int CoLast     = 33;
   localparam int AngStage   = 34;
   localparam int DivInit    = 35;
   localparam int DivFirst   = 36;
   localparam int KLast      = 55;
   localparam int RLast      = 56;
   localparam int KStage     = 57;
   localparam int MulStage   = 58;
   localparam int ProdStage  = 59;
   localparam int LatInit    = 60;
   localparam int LatFirst   = 61;
   localparam int LatLast    = 92;
   localparam int AxInit     = 61;
   localparam int AxFirst    = 62;
   localparam int AxLast     = 93;
   localparam int OutStage   = 94;

   localparam logic [15:0]        FocalReset = 16'd8400;
   localparam logic [22:0]        AngNinety  = 23'd5898240;
   localparam logic [22:0]        AngClamp   = 23'd5570560;
   localparam logic signed [25:0] AngClampS  = 26'sd5570560;
   localparam logic signed [25:0] AngNinetyS = 26'sd5898240;
   localparam logic [20:0]        LatBase    = 21'd838861;
   localparam logic [15:0]        LatGain    = 16'd35652;
   localparam logic [33:0]        AxBase     = 34'd20133;
   localparam logic signed [20:0] DzOffset   = 21'sd26214;
   localparam logic [22:0]        Term2Gain  = 23'd8160438;
   localparam logic [18:0]        Term3Gain  = 19'd429497;

   typedef struct packed {
      logic                fin;
      logic [19:0]         z;
      logic signed [16:0]  c;
      logic [30:0]         sq_rem;
      logic [15:0]         sq_root;
      logic [35:0]         zq_rem;
      logic [17:0]         zq_root;
      logic [39:0]         dz2;
      logic [42:0]         t2lo;
      logic [42:0]         t2hi;
      logic [22:0]         term2;
      logic [39:0]         zz;
      logic signed [34:0]  cx;
      logic signed [34:0]  cy;
      logic signed [25:0]  ang;
      logic [22:0]         a;
      logic [22:0]         d;
      logic [23:0]         k_rem;
      logic [19:0]         k_num;
      logic [19:0]         k_quo;
      logic [23:0]         r_rem;
      logic [20:0]         r_num;
      logic [20:0]         r_quo;
      logic [20:0]         kk;
      logic [41:0]         rr;
      logic [40:0]         plo;
      logic [40:0]         phi;
      logic [39:0]         q3lo;
      logic [39:0]         q3hi;
      logic [36:0]         nlat;
      logic [35:0]         n3;
      logic                l_sat;
      logic [16:0]         l_rem;
      logic [31:0]         l_num;
      logic [31:0]         l_quo;
      logic                x_sat;
      logic [18:0]         x_rem;
      logic [31:0]         x_num;
      logic [31:0]         x_quo;
      logic [31:0]         lat;
      logic [31:0]         ax;
      logic                vres;
   } stage_type;

   function automatic logic signed [25:0] atan_deg(input int i);
      case (i)
         0:  return 26'sd2949120;
         1:  return 26'sd1740967;
         2:  return 26'sd919879;
         3:  return 26'sd466945;
         4:  return 26'sd234379;
         5:  return 26'sd117304;
         6:  return 26'sd58666;
         7:  return 26'sd29335;
         8:  return 26'sd14668;
         9:  return 26'sd7334;
         10: return 26'sd3667;
         11: return 26'sd1833;
         12: return 26'sd917;
         13: return 26'sd458;
         14: return 26'sd229;
         15: return 26'sd115;
         default: return 26'sd0;
      endcase
   endfunction

   // shift toward zero
   function automatic logic signed [34:0] shr_sym(input logic signed [34:0] v, input int i);
      logic signed [34:0] mag;
      mag = v[34] ? -v : v;
      mag = mag >> i;
      return v[34] ? -mag : mag;
   endfunction

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [40:0] div_step(input logic [39:0] rem_sh, input logic [39:0] dvs);
      logic [39:0] diff;
      diff = rem_sh - dvs;
      if (rem_sh >= dvs) begin
         return {1'b1, diff};
      end
      return {1'b0, rem_sh};
   endfunction

   // one square root step at root bit b: {new remainder, new root}
   function automatic logic [59:0] sqrt_step(input logic [39:0] rem, input logic [19:0] root,
                                             input int b);
      logic [39:0] cand;
      cand = ({20'b0, root} << (b + 1)) + (40'd1 << (2 * b));
      if (rem >= cand) begin
         return {rem - cand, root | (20'd1 << b)};
      end
      return {rem, root};
   endfunction

   function automatic stage_type stage_step(input stage_type p, input int s,
                                            input logic [15:0] focal);
      stage_type          n;
      logic signed [33:0] csq;
      logic signed [20:0] dz;
      logic signed [41:0] dzsq;
      logic [62:0]        t2;
      logic [59:0]        sqv;
      logic [40:0]        dv;
      logic signed [34:0] sx;
      logic signed [34:0] sy;
      logic [38:0]        na;
      logic [60:0]        plat;
      logic [60:0]        p3;
      logic [33:0]        sum;
      n = p;
      if (s == 0) begin
         csq       = p.c * p.c;
         n.sq_rem  = 31'(34'h4000_0000 - csq);
         n.sq_root = '0;
         n.zq_rem  = {p.z, 16'b0};
         n.zq_root = '0;
      end
      if (s >= SqFirst && s <= SqLast) begin
         sqv       = sqrt_step(40'(p.sq_rem), 20'(p.sq_root), SqLast - s);
         n.sq_rem  = sqv[50:20];
         n.sq_root = sqv[15:0];
      end
      if (s >= SqFirst && s <= ZqLast) begin
         sqv       = sqrt_step(40'(p.zq_rem), 20'(p.zq_root), ZqLast - s);
         n.zq_rem  = sqv[55:20];
         n.zq_root = sqv[17:0];
      end
      if (s == DzStage) begin
         dz    = $signed({1'b0, p.z}) - DzOffset;
         dzsq  = dz * dz;
         n.dz2 = dzsq[39:0];
         n.zz  = p.z * p.z;
      end
      if (s == T2MulStage) begin
         n.t2lo = p.dz2[19:0] * Term2Gain;
         n.t2hi = p.dz2[39:20] * Term2Gain;
      end
      if (s == T2SumStage) begin
         t2      = {p.t2hi, 20'b0} + 63'(p.t2lo);
         n.term2 = t2[62:40];
      end
      if (s == CoInit) begin
         sx = {{4{p.c[16]}}, p.c, 14'b0};
         sy = {5'b0, p.sq_root, 14'b0};
         if (p.c[16]) begin
            n.cx  = sy;
            n.cy  = -sx;
            n.ang = AngNinetyS;
         end else begin
            n.cx  = sx;
            n.cy  = sy;
            n.ang = 26'sd0;
         end
      end
      if (s >= CoFirst && s <= CoLast) begin
         if (p.cy > 35'sd0) begin
            n.cx  = p.cx + shr_sym(p.cy, s - CoFirst);
            n.cy  = p.cy - shr_sym(p.cx, s - CoFirst);
            n.ang = p.ang + atan_deg(s - CoFirst);
         end else begin
            n.cx  = p.cx - shr_sym(p.cy, s - CoFirst);
            n.cy  = p.cy + shr_sym(p.cx, s - CoFirst);
            n.ang = p.ang - atan_deg(s - CoFirst);
         end
      end
      if (s == AngStage) begin
         if (p.ang < 26'sd0) begin
            n.a = '0;
         end else if (p.ang > AngClampS) begin
            n.a = AngClamp;
         end else begin
            n.a = p.ang[22:0];
         end
         n.d = AngNinety - n.a;
      end
      if (s == DivInit) begin
         na      = p.a * LatGain;
         n.k_rem = 24'(na[38:20]);
         n.k_num = na[19:0];
         n.k_quo = '0;
         n.r_rem = 24'(p.a[22:5]);
         n.r_num = {p.a[4:0], 16'b0};
         n.r_quo = '0;
      end
      if (s >= DivFirst && s <= KLast) begin
         dv      = div_step({15'b0, p.k_rem, p.k_num[19]}, 40'(p.d));
         n.k_rem = dv[23:0];
         n.k_num = p.k_num << 1;
         n.k_quo = {p.k_quo[18:0], dv[40]};
      end
      if (s >= DivFirst && s <= RLast) begin
         dv      = div_step({15'b0, p.r_rem, p.r_num[20]}, 40'(p.d));
         n.r_rem = dv[23:0];
         n.r_num = p.r_num << 1;
         n.r_quo = {p.r_quo[19:0], dv[40]};
      end
      if (s == KStage) begin
         n.kk = LatBase + 21'(p.k_quo);
         n.rr = p.r_quo * p.r_quo;
      end
      if (s == MulStage) begin
         n.plo  = p.zz[19:0] * p.kk;
         n.phi  = p.zz[39:20] * p.kk;
         n.q3lo = p.rr[20:0] * Term3Gain;
         n.q3hi = p.rr[41:21] * Term3Gain;
      end
      if (s == ProdStage) begin
         plat   = {p.phi, 20'b0} + 61'(p.plo);
         n.nlat = plat[60:24];
         p3     = {p.q3hi, 21'b0} + 61'(p.q3lo);
         n.n3   = p3[59:24];
      end
      if (s == LatInit) begin
         n.l_sat = (focal == 16'd0) || ({11'b0, p.nlat[36:32]} >= focal);
         n.l_rem = 17'(p.nlat[36:32]);
         n.l_num = p.nlat[31:0];
         n.l_quo = '0;
      end
      if (s >= LatFirst && s <= LatLast) begin
         dv      = div_step({23'b0, p.l_rem[15:0], p.l_num[31]}, 40'(focal));
         n.l_rem = dv[16:0];
         n.l_num = p.l_num << 1;
         n.l_quo = {p.l_quo[30:0], dv[40]};
      end
      if (s == AxInit) begin
         n.x_sat = (p.zq_root == 18'd0) || ({14'b0, p.n3[35:32]} >= p.zq_root);
         n.x_rem = 19'(p.n3[35:32]);
         n.x_num = p.n3[31:0];
         n.x_quo = '0;
      end
      if (s >= AxFirst && s <= AxLast) begin
         dv      = div_step({21'b0, p.x_rem[17:0], p.x_num[31]}, 40'(p.zq_root));
         n.x_rem = dv[18:0];
         n.x_num = p.x_num << 1;
         n.x_quo = {p.x_quo[30:0], dv[40]};
      end
      if (s == OutStage) begin
         sum    = AxBase + 34'(p.term2) + 34'(p.x_quo);
         n.lat  = (!p.fin || p.l_sat) ? '1 : p.l_quo;
         n.ax   = (!p.fin || p.x_sat || (sum[33:32] != 2'b00)) ? '1 : sum[31:0];
         n.vres = p.fin;
      end
      return n;
   endfunction

endpackage

// File: rtl/depth_sensor_noise_sigma.sv
// Top level of the per pixel depth sensor noise sigma pipeline.
//
// Usage: one request per pixel on req_* (depth Q4.16 m, normal z Q1.15, finite flag),
// one response per request on rsp_* (lateral and axial sigma in 2^-24 m, valid flag).
// Both channels use valid/ready; focal length (Q12.4 px) is written on csr_wr_en and
// csr_wr_data while no request is in flight.
// Pipeline: registered stages of square root steps, one CORDIC iteration per stage
// and one quotient bit per stage for each of the four divisions.
// Throughput: one request per cycle while the pipeline is not stalled; every stage
// carries its own valid bit.
// Reset: all valid bits clear, focal length returns to 8400 (525 px).
// Stall: while a response waits and rsp_ready is low, the whole pipeline holds and
// req_ready is low; nothing is dropped or repeated.
module depth_sensor_noise_sigma
   import dsns_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [19:0]        req_depth_z,
   input  logic signed [15:0] req_normal_z,
   input  logic               req_inputs_finite,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_sigma_lateral,
   output logic [31:0]        rsp_sigma_axial,
   output logic               rsp_valid_res,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   logic [15:0]            focal_ff;
   logic [15:0]            focal_in;
   logic [NumStages-1:0]   vld_ff;
   logic [NumStages-1:0]   vld_in;
   stage_type              stg_ff [NumStages];
   stage_type              stg_in [NumStages];
   stage_type              head;
   logic                   advance;

   assign advance   = !vld_ff[NumStages-1] || rsp_ready;
   assign req_ready = advance;
   assign focal_in  = csr_wr_en ? csr_wr_data : focal_ff;
   assign vld_in    = {vld_ff[NumStages-2:0], req_valid};

   always_comb begin
      head     = '0;
      head.z   = req_depth_z;
      head.c   = -$signed({req_normal_z[15], req_normal_z});
      head.fin = req_inputs_finite;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= FocalReset;
         vld_ff   <= '0;
      end else begin
         focal_ff <= focal_in;
         if (advance) begin
            vld_ff <= vld_in;
         end
      end
   end

   for (genvar k = 0; k < NumStages; k++) begin : g_stage
      if (k == 0) begin : g_head
         always_comb begin
            stg_in[k] = stage_step(head, k, focal_ff);
         end
      end else begin : g_body
         always_comb begin
            stg_in[k] = stage_step(stg_ff[k-1], k, focal_ff);
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign rsp_valid         = vld_ff[NumStages-1];
   assign rsp_sigma_lateral = stg_ff[NumStages-1].lat;
   assign rsp_sigma_axial   = stg_ff[NumStages-1].ax;
   assign rsp_valid_res     = stg_ff[NumStages-1].vres;

endmodule

// File: rtl/dsns_checker.sv
// Port level checks of the depth sensor noise sigma block and their bind.
module dsns_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_sigma_lateral,
   input logic [31:0] rsp_sigma_axial,
   input logic        rsp_valid_res
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sigma_lateral)
         && $stable(rsp_sigma_axial) && $stable(rsp_valid_res))
      else $error("stalled response changed");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response stall");

   a_invalid_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_sigma_lateral == 32'hFFFF_FFFF
         && rsp_sigma_axial == 32'hFFFF_FFFF)
      else $error("invalid response not saturated");

   a_axial_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_sigma_axial >= 32'd20133)
      else $error("axial sigma below constant term");

endmodule

bind depth_sensor_noise_sigma dsns_checker u_dsns_checker (.*);
